>>> rtl/ldr_boot_stream_loader_core_macros.svh
// Assertion macros shared by the boot stream loader RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef LDR_BOOT_STREAM_LOADER_CORE_MACROS_SVH
`define LDR_BOOT_STREAM_LOADER_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LDR_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LDR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ldr_pkg.sv
// Types and constants of the boot stream loader.
// No dependencies; used by the interfaces and every RTL module.
package ldr_pkg;

    localparam int HDR_BYTES = 16;

    // Header signature bytes accepted in bits 31..24 of the code word.
    localparam logic [7:0] SIG_AD = 8'hAD;
    localparam logic [7:0] SIG_AC = 8'hAC;
    localparam logic [7:0] SIG_AB = 8'hAB;

    // Flag bit positions in the code word.
    localparam int FLAG_FILL   = 8;
    localparam int FLAG_IGNORE = 12;
    localparam int FLAG_FIRST  = 14;
    localparam int FLAG_FINAL  = 15;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_L1_BASE   = 3'd0,
        CFG_L1_SIZE   = 3'd1,
        CFG_L2_BASE   = 3'd2,
        CFG_L2_SIZE   = 3'd3,
        CFG_IMAGE_LEN = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_FILL   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_BAD_SIG   = 2'd1;
    localparam logic [1:0] ST_NO_WINDOW = 2'd2;
    localparam logic [1:0] ST_SHORT     = 2'd3;

    localparam logic WIN_L1 = 1'b0;
    localparam logic WIN_L2 = 1'b1;

    typedef struct packed {
        logic [31:0] l1_window_base;
        logic [31:0] l1_window_size;
        logic [31:0] l2_window_base;
        logic [31:0] l2_window_size;
        logic [31:0] image_length;
    } cfg_regs_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        window;
        logic [31:0] write_offset;
        logic [7:0]  write_byte;
        logic [31:0] fill_count;
        logic [1:0]  status;
        logic [31:0] entry_address;
        logic        last;
    } result_t;

    // Result push strobes from the parser to the result queue.
    typedef struct packed {
        logic v0;
        logic v1;
    } push_t;

endpackage

>>> rtl/ldr_if.sv
// Valid/ready channel interfaces of the boot stream loader: input, result and configuration.
// Depends on ldr_pkg for the configuration index width.
interface ldr_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] stream_byte;

    modport source (output valid, output operation, output stream_byte, input ready);
    modport sink (input valid, input operation, input stream_byte, output ready);
endinterface

interface ldr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        window;
    logic [31:0] write_offset;
    logic [7:0]  write_byte;
    logic [31:0] fill_count;
    logic [1:0]  status;
    logic [31:0] entry_address;
    logic        last;

    modport source (output valid, output kind, output window, output write_offset,
                    output write_byte, output fill_count, output status,
                    output entry_address, output last, input ready);
    modport sink (input valid, input kind, input window, input write_offset,
                  input write_byte, input fill_count, input status,
                  input entry_address, input last, output ready);
endinterface

interface ldr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ldr_pkg::CFG_IDX_W-1:0]  index;
    logic [31:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/ldr_parser.sv
// Input register and per-byte header/payload parser of the boot stream loader.
// Depends on ldr_pkg, ldr_if and the assertion macro header.
`include "ldr_boot_stream_loader_core_macros.svh"

module ldr_parser (
    input  logic                clk,
    input  logic                rst_n,
    ldr_in_if.sink              item_in,
    input  ldr_pkg::cfg_regs_t  cfg_regs,
    input  logic                fifo_room,
    output ldr_pkg::push_t      push,
    output ldr_pkg::result_t    res0,
    output ldr_pkg::result_t    res1
);

    logic       stage_valid_reg;
    logic       stage_op_reg;
    logic [7:0] stage_byte_reg;
    logic       take;

    ldr_pkg::phase_t phase_reg, phase_next;
    logic [31:0] hdr_word_reg [4];
    logic [3:0]  hidx_reg, hidx_next;
    logic [31:0] prem_reg, prem_next;
    logic [31:0] poff_reg, poff_next;
    logic        pwin_reg, pwin_next;
    logic        pdisc_reg, pdisc_next;
    logic        final_reg, final_next;
    logic [31:0] spos_reg, spos_next;
    logic [31:0] entry_reg, entry_next;

    assign take = stage_valid_reg && fifo_room;
    assign item_in.ready = !stage_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item_in.valid && item_in.ready)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            stage_op_reg   <= item_in.operation;
            stage_byte_reg <= item_in.stream_byte;
        end
    end

    // Header bytes land little-endian in their word as they arrive.
    always_ff @(posedge clk)
    begin
        if (take && !stage_op_reg && phase_reg == ldr_pkg::PH_HEADER)
        begin
            hdr_word_reg[hidx_reg[3:2]][{hidx_reg[1:0], 3'b000} +: 8] <= stage_byte_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ldr_pkg::PH_IDLE;
            hidx_reg  <= '0;
            prem_reg  <= '0;
            poff_reg  <= '0;
            pwin_reg  <= 1'b0;
            pdisc_reg <= 1'b0;
            final_reg <= 1'b0;
            spos_reg  <= '0;
            entry_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hidx_reg  <= hidx_next;
            prem_reg  <= prem_next;
            poff_reg  <= poff_next;
            pwin_reg  <= pwin_next;
            pdisc_reg <= pdisc_next;
            final_reg <= final_next;
            spos_reg  <= spos_next;
            entry_reg <= entry_next;
        end
    end

    always_comb
    begin
        logic [31:0] code;
        logic [31:0] addr;
        logic [31:0] count;
        logic [7:0]  sig;
        logic [31:0] spos_inc;
        logic [31:0] l1_rel;
        logic [31:0] l2_rel;
        logic        l1_hit;
        logic        l2_hit;
        logic        fill;
        logic        skip;
        logic        win;
        logic [31:0] off;
        logic        end_req;
        logic        st_req;
        logic [1:0]  st_code;
        ldr_pkg::result_t st_res;

        code     = hdr_word_reg[0];
        addr     = hdr_word_reg[1];
        count    = hdr_word_reg[2];
        sig      = code[31:24];
        spos_inc = spos_reg + 32'd1;
        l1_rel   = addr - cfg_regs.l1_window_base;
        l2_rel   = addr - cfg_regs.l2_window_base;
        l1_hit   = (addr >= cfg_regs.l1_window_base) && (l1_rel < cfg_regs.l1_window_size);
        l2_hit   = (addr >= cfg_regs.l2_window_base) && (l2_rel < cfg_regs.l2_window_size);
        fill     = code[ldr_pkg::FLAG_FILL];
        skip     = code[ldr_pkg::FLAG_IGNORE] || (count == 32'd0);
        win      = l1_hit ? ldr_pkg::WIN_L1 : ldr_pkg::WIN_L2;
        off      = l1_hit ? l1_rel : l2_rel;
        end_req  = 1'b0;
        st_req   = 1'b0;
        st_code  = ldr_pkg::ST_DONE;
        st_res   = '0;

        phase_next = phase_reg;
        hidx_next  = hidx_reg;
        prem_next  = prem_reg;
        poff_next  = poff_reg;
        pwin_next  = pwin_reg;
        pdisc_next = pdisc_reg;
        final_next = final_reg;
        spos_next  = spos_reg;
        entry_next = entry_reg;
        push       = '0;
        res0       = '0;
        res1       = '0;

        if (take)
        begin
            if (stage_op_reg)
            begin
                phase_next = ldr_pkg::PH_HEADER;
                hidx_next  = '0;
                prem_next  = '0;
                poff_next  = '0;
                pwin_next  = 1'b0;
                pdisc_next = 1'b0;
                final_next = 1'b0;
                spos_next  = '0;
                if (cfg_regs.image_length < 32'(ldr_pkg::HDR_BYTES))
                begin
                    st_req  = 1'b1;
                    st_code = ldr_pkg::ST_SHORT;
                end
            end
            else
            begin
                case (phase_reg)
                    ldr_pkg::PH_HEADER:
                    begin
                        spos_next = spos_inc;
                        hidx_next = hidx_reg + 4'd1;
                        if (hidx_reg == 4'(ldr_pkg::HDR_BYTES - 1))
                        begin
                            if (sig != ldr_pkg::SIG_AD && sig != ldr_pkg::SIG_AC &&
                                sig != ldr_pkg::SIG_AB)
                            begin
                                st_req  = 1'b1;
                                st_code = ldr_pkg::ST_BAD_SIG;
                            end
                            else
                            begin
                                final_next = final_reg | code[ldr_pkg::FLAG_FINAL];
                                if (code[ldr_pkg::FLAG_FIRST])
                                begin
                                    entry_next = addr;
                                end
                                if (skip)
                                begin
                                    if (!fill && count != 32'd0 && !final_next)
                                    begin
                                        phase_next = ldr_pkg::PH_PAYLOAD;
                                        prem_next  = count;
                                        pdisc_next = 1'b1;
                                        poff_next  = '0;
                                        pwin_next  = 1'b0;
                                    end
                                    else
                                    begin
                                        end_req = 1'b1;
                                    end
                                end
                                else if (!l1_hit && !l2_hit)
                                begin
                                    st_req  = 1'b1;
                                    st_code = ldr_pkg::ST_NO_WINDOW;
                                end
                                else if (fill)
                                begin
                                    push.v0            = 1'b1;
                                    res0.kind          = ldr_pkg::KIND_FILL;
                                    res0.window        = win;
                                    res0.write_offset  = off;
                                    res0.write_byte    = hdr_word_reg[3][7:0];
                                    res0.fill_count    = count;
                                    end_req            = 1'b1;
                                end
                                else if ({1'b0, spos_inc} + {1'b0, count} >
                                         {1'b0, cfg_regs.image_length})
                                begin
                                    st_req  = 1'b1;
                                    st_code = ldr_pkg::ST_SHORT;
                                end
                                else
                                begin
                                    phase_next = ldr_pkg::PH_PAYLOAD;
                                    prem_next  = count;
                                    pdisc_next = 1'b0;
                                    poff_next  = off;
                                    pwin_next  = win;
                                end
                            end
                        end
                    end
                    ldr_pkg::PH_PAYLOAD:
                    begin
                        spos_next = spos_inc;
                        prem_next = prem_reg - 32'd1;
                        if (!pdisc_reg)
                        begin
                            push.v0           = 1'b1;
                            res0.kind         = ldr_pkg::KIND_WRITE;
                            res0.window       = pwin_reg;
                            res0.write_offset = poff_reg;
                            res0.write_byte   = stage_byte_reg;
                            poff_next         = poff_reg + 32'd1;
                        end
                        if (prem_next == 32'd0)
                        begin
                            end_req = 1'b1;
                        end
                        else if (spos_inc >= cfg_regs.image_length)
                        begin
                            st_req  = 1'b1;
                            st_code = ldr_pkg::ST_SHORT;
                        end
                    end
                    default:
                    begin
                        phase_next = ldr_pkg::PH_IDLE;
                    end
                endcase
            end
        end

        // Block boundary: finish the load, flag a short image, or await the next header.
        if (end_req)
        begin
            if (final_next)
            begin
                st_req  = 1'b1;
                st_code = ldr_pkg::ST_DONE;
            end
            else if ({1'b0, spos_inc} + 33'(ldr_pkg::HDR_BYTES) >
                     {1'b0, cfg_regs.image_length})
            begin
                st_req  = 1'b1;
                st_code = ldr_pkg::ST_SHORT;
            end
            else
            begin
                phase_next = ldr_pkg::PH_HEADER;
                hidx_next  = '0;
            end
        end

        // Any status ends the load; it follows any write or fill of the same byte.
        if (st_req)
        begin
            phase_next           = ldr_pkg::PH_IDLE;
            st_res.kind          = ldr_pkg::KIND_STATUS;
            st_res.status        = st_code;
            st_res.entry_address = entry_next;
            if (push.v0)
            begin
                push.v1 = 1'b1;
                res1    = st_res;
            end
            else
            begin
                push.v0 = 1'b1;
                res0    = st_res;
            end
        end

        if (push.v1)
        begin
            res1.last = 1'b1;
        end
        else if (push.v0)
        begin
            res0.last = 1'b1;
        end
    end

    `LDR_ASSERT_IMPLIES(a_second_needs_first, push.v1, push.v0,
        "second result pushed without a first")
    `LDR_ASSERT_IMPLIES(a_last_on_final, push.v0, res0.last != push.v1,
        "last flag not on the final result of the byte")
    `LDR_ASSERT_NEXT(a_status_goes_idle, push.v1 || (push.v0 && res0.kind == ldr_pkg::KIND_STATUS),
        (res1.kind != ldr_pkg::KIND_STATUS && $past(push.v1)) || phase_reg == ldr_pkg::PH_IDLE,
        "parser not idle after a status result")
    `LDR_ASSERT_NEXT(a_stage_holds, stage_valid_reg && !fifo_room, stage_valid_reg,
        "input word dropped while the result queue was full")

endmodule

>>> rtl/ldr_res_fifo.sv
// Four-entry result queue: up to two in a cycle, one out a cycle while ready.
// Depends on ldr_pkg, ldr_if and the assertion macro header.
`include "ldr_boot_stream_loader_core_macros.svh"

module ldr_res_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  ldr_pkg::push_t    push,
    input  ldr_pkg::result_t  res0,
    input  ldr_pkg::result_t  res1,
    output logic              fifo_room,
    ldr_out_if.source         result_out
);

    localparam int DEPTH = 4;

    ldr_pkg::result_t mem_reg [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;
    logic [1:0] n_push;
    ldr_pkg::result_t head;

    // Room for two results means any byte can be taken this cycle.
    assign fifo_room = count_reg <= 3'(DEPTH - 2);
    assign pop       = result_out.valid && result_out.ready;
    assign n_push    = {1'b0, push.v0} + {1'b0, push.v1};

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + n_push;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, n_push} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem_reg[wr_ptr_reg] <= res0;
        end
        if (push.v1)
        begin
            mem_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

    assign head                     = mem_reg[rd_ptr_reg];
    assign result_out.valid         = count_reg != 3'd0;
    assign result_out.kind          = head.kind;
    assign result_out.window        = head.window;
    assign result_out.write_offset  = head.write_offset;
    assign result_out.write_byte    = head.write_byte;
    assign result_out.fill_count    = head.fill_count;
    assign result_out.status        = head.status;
    assign result_out.entry_address = head.entry_address;
    assign result_out.last          = head.last;

    `LDR_ASSERT_IMPLIES(a_count_max, 1'b1, count_reg <= 3'(DEPTH),
        "result queue count beyond its depth")
    `LDR_ASSERT_IMPLIES(a_push_room, push.v0, count_reg <= 3'(DEPTH - 2),
        "results pushed without room for two")
    `LDR_ASSERT_NEXT(a_pop_drains, pop && !push.v0, count_reg == $past(count_reg) - 3'd1,
        "pop did not reduce the queue count")

endmodule

>>> rtl/ldr_boot_stream_loader_core.sv
// Top level of the boot stream loader: configuration registers, parser and result queue.
// Depends on ldr_pkg, ldr_if, ldr_parser and ldr_res_fifo.
//
// Channel     Role   Word
// item_in     sink   operation (begin or stream byte) and stream_byte
// result_out  source byte write, fill run or status, with last on the final result
// cfg         sink   register index and 32-bit write data; always ready
//
// Each input word is registered, then parsed against the parser state and
// pushed as one or two results into a four-entry result queue.
// A new word is taken every cycle while the queue holds at most two results;
// a byte that yields a write plus a status puts two results into the queue.
// Reset clears the parser to idle, zeroes the window and length registers
// and empties the queue. A stall on result_out fills the queue and then
// holds the input register, which drops item_in.ready.
module ldr_boot_stream_loader_core (
    input  logic       clk,
    input  logic       rst_n,
    ldr_in_if.sink     item_in,
    ldr_out_if.source  result_out,
    ldr_cfg_if.sink    cfg
);

    ldr_pkg::cfg_regs_t cfg_reg;
    ldr_pkg::push_t     push;
    ldr_pkg::result_t   res0;
    ldr_pkg::result_t   res1;
    logic               fifo_room;

    // Configuration writes are taken in any cycle; unknown indexes are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                ldr_pkg::CFG_L1_BASE:   cfg_reg.l1_window_base <= cfg.data;
                ldr_pkg::CFG_L1_SIZE:   cfg_reg.l1_window_size <= cfg.data;
                ldr_pkg::CFG_L2_BASE:   cfg_reg.l2_window_base <= cfg.data;
                ldr_pkg::CFG_L2_SIZE:   cfg_reg.l2_window_size <= cfg.data;
                ldr_pkg::CFG_IMAGE_LEN: cfg_reg.image_length   <= cfg.data;
                default:                cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Header assembly, block decode, window mapping and payload counting.
    ldr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_in   (item_in),
        .cfg_regs  (cfg_reg),
        .fifo_room (fifo_room),
        .push      (push),
        .res0      (res0),
        .res1      (res1)
    );

    // Decouples the two-results-per-byte burst from the output, one per cycle while ready.
    ldr_res_fifo u_res_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .res0       (res0),
        .res1       (res1),
        .fifo_room  (fifo_room),
        .result_out (result_out)
    );

endmodule
